// ===== hdl/hamming_code_encoder_macros.svh =====
// Assertion macros shared by the Hamming encoder RTL.
`ifndef HAMMING_CODE_ENCODER_MACROS_SVH
`define HAMMING_CODE_ENCODER_MACROS_SVH

// Assertion checked on every rising edge of aclk while out of reset.
`define HCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication checked on every rising edge of aclk while out of reset.
`define HCE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hce_pkg.sv =====
// Constants and helper functions for the Hamming encoder.
package hce_pkg;

    localparam int DATA_W  = 57;
    localparam int CODE_W  = 63;
    localparam int LEN_W   = 6;
    localparam int CHECK_W = 3;
    localparam int PAR_N   = 6;

    localparam int MAX_DATA_BITS = 57;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_DATA_BITS  = 1'b0;
    localparam logic REG_ODD_PARITY = 1'b1;

    localparam logic [LEN_W-1:0] DATA_BITS_RESET = 6'd4;

    // Spread the data bits over the positions that are not powers of two.
    function automatic logic [CODE_W-1:0] place_data(input logic [DATA_W-1:0] d);
        logic [CODE_W-1:0] c;
        int                k;
        c = '0;
        k = 0;
        for (int p = 1; p <= CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (k < DATA_W) begin
                    c[p-1] = d[k];
                end
                k++;
            end
        end
        return c;
    endfunction

    // Raw even parity of each check group; the check positions themselves are zero.
    function automatic logic [PAR_N-1:0] group_parity(input logic [CODE_W-1:0] c);
        logic [PAR_N-1:0] par;
        par = '0;
        for (int i = 0; i < PAR_N; i++) begin
            for (int p = 1; p <= CODE_W; p++) begin
                if (((p >> i) & 1) != 0) begin
                    par[i] = par[i] ^ c[p-1];
                end
            end
        end
        return par;
    endfunction

    // Smallest r of at least one with 2^r >= m + r + 1.
    function automatic logic [CHECK_W-1:0] check_count_for(input logic [LEN_W-1:0] m);
        logic [CHECK_W-1:0] r;
        r = 3'd7;
        for (int c = 7; c >= 1; c--) begin
            if ((1 << c) >= int'(m) + c + 1) begin
                r = CHECK_W'(c);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/hamming_code_encoder.sv =====
// Hamming encoder: streaming data words in, codewords with check bits out.
//
// Each accepted data word becomes one Hamming codeword with check bits at the
// power-of-two positions, even or odd parity as configured. The datapath is a
// three-stage pipeline (word clamp and masking, data placement with group
// parity, check-bit merge into the output register), so a word passes each
// stage register on its way to the master side, and one word is taken every
// cycle as long as the master side keeps up. Back pressure stalls the whole
// pipeline without losing or repeating a word. Registers: data_bits at byte
// address 0 and odd_parity at byte address 4; write them only while idle.
`include "hamming_code_encoder_macros.svh"

module hamming_code_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hce_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hce_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hce_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hce_pkg::S_TDATA_W-1:0]  s_tdata,  // [56:0] data_word, [63:57] zero
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hce_pkg::M_TDATA_W-1:0]  m_tdata   // [62:0] code_word,
                                                      // [68:63] code_length,
                                                      // [71:69] check_count
);
    import hce_pkg::*;

    localparam int MAX_M = (MAX_DATA_BITS > 63) ? 63 : MAX_DATA_BITS;

    // Configuration registers
    logic [LEN_W-1:0] data_bits_reg;
    logic             odd_parity_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_bits_reg  <= DATA_BITS_RESET;
            odd_parity_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_DATA_BITS:  data_bits_reg  <= pwdata[LEN_W-1:0];
                REG_ODD_PARITY: odd_parity_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DATA_BITS:  prdata = {{(APB_DATA_W-LEN_W){1'b0}}, data_bits_reg};
            REG_ODD_PARITY: prdata = {{(APB_DATA_W-1){1'b0}}, odd_parity_reg};
            default:        prdata = '0;
        endcase
    end

    // Pipeline advance: a stage loads when it is empty or its successor loads.
    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // Stage 1: clamp the data bit count, derive r and n, mask unused bits.
    logic [LEN_W-1:0]   m_eff;
    logic [CHECK_W-1:0] r_comb;
    logic [LEN_W:0]     n_sum;
    logic [LEN_W-1:0]   n_comb;
    logic [DATA_W-1:0]  data_mask;

    always_comb begin
        if (data_bits_reg == '0) begin
            m_eff = LEN_W'(1);
        end else if (int'(data_bits_reg) > MAX_M) begin
            m_eff = LEN_W'(MAX_M);
        end else begin
            m_eff = data_bits_reg;
        end
        r_comb = check_count_for(m_eff);
        n_sum  = {1'b0, m_eff} + {{(LEN_W+1-CHECK_W){1'b0}}, r_comb};
        n_comb = n_sum[LEN_W] ? {LEN_W{1'b1}} : n_sum[LEN_W-1:0];
        for (int k = 0; k < DATA_W; k++) begin
            data_mask[k] = (k < int'(m_eff));
        end
    end

    logic [DATA_W-1:0]  data1_reg;
    logic [CHECK_W-1:0] r1_reg;
    logic [LEN_W-1:0]   n1_reg;
    logic               odd1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
        if (en1) begin
            data1_reg <= s_tdata[DATA_W-1:0] & data_mask;
            r1_reg    <= r_comb;
            n1_reg    <= n_comb;
            odd1_reg  <= odd_parity_reg;
        end
    end

    // Stage 2: place data bits and form the raw parity of every check group.
    logic [CODE_W-1:0]  code_comb;
    logic [CODE_W-1:0]  code2_reg;
    logic [PAR_N-1:0]   par2_reg;
    logic [CHECK_W-1:0] r2_reg;
    logic [LEN_W-1:0]   n2_reg;
    logic               odd2_reg;

    assign code_comb = place_data(data1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
        if (en2) begin
            code2_reg <= code_comb;
            par2_reg  <= group_parity(code_comb);
            r2_reg    <= r1_reg;
            n2_reg    <= n1_reg;
            odd2_reg  <= odd1_reg;
        end
    end

    // Stage 3: merge the check bits in use into the output register.
    logic [CODE_W-1:0]  code_final;
    logic [CODE_W-1:0]  code3_reg;
    logic [LEN_W-1:0]   len3_reg;
    logic [CHECK_W-1:0] chk3_reg;

    always_comb begin
        code_final = code2_reg;
        for (int i = 0; i < PAR_N; i++) begin
            code_final[(1 << i) - 1] = (i < int'(r2_reg)) && (par2_reg[i] ^ odd2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
        if (en3) begin
            code3_reg <= code_final;
            len3_reg  <= n2_reg;
            chk3_reg  <= r2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {chk3_reg, len3_reg, code3_reg};

    // A stalled input side means the first stage holds a word.
    `HCE_ASSERT_IMPL(a_stall_full, !s_tready, v1_reg, "input stalled with stage 1 empty")
    // No codeword bit is set above the codeword length.
    `HCE_ASSERT_IMPL(a_code_len, m_tvalid, (code3_reg >> len3_reg) == '0,
                     "codeword bit set above code_length")
    // Every codeword carries at least one check bit and more than one bit in total.
    `HCE_ASSERT_IMPL(a_len_min, m_tvalid, chk3_reg != '0 && len3_reg > LEN_W'(1),
                     "codeword shorter than possible")

endmodule

// ===== tb/sv/hamming_code_encoder_tb.sv =====
// Self-checking testbench for the variable-length Hamming encoder.
`timescale 1ns / 1ps

module hamming_code_encoder_tb;
    import hce_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PIPE_SETTLE   = 6;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_WORDS   = 107;

    typedef struct packed {
        logic [CHECK_W-1:0] check_count;
        logic [LEN_W-1:0]   code_length;
        logic [CODE_W-1:0]  code_word;
    } codeword_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [56:0] data_word, [63:57] zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [62:0] code_word, [68:63] code_length,
                                      // [71:69] check_count

    codeword_t         pending_codewords[$];
    codeword_t         oldest_codeword;
    logic [LEN_W-1:0]  cfg_data_bits;
    logic              cfg_odd_parity;
    logic              no_idle;
    int                error_count;
    int                words_sent;
    int                codewords_checked;
    int                settings_used;
    int                cycle_count;

    hamming_code_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d codewords outstanding.",
                     cycle_count, pending_codewords.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Expected codeword for one data word under the given register values.
    function automatic codeword_t hamming_encode(input logic [DATA_W-1:0] word,
                                                 input logic [LEN_W-1:0]  width_cfg,
                                                 input logic              odd_cfg);
        codeword_t result;
        int        m;
        int        r;
        int        n;
        int        k;
        int        chk;
        logic      par;
        m = int'(width_cfg);
        if (m == 0) begin
            m = 1;
        end
        if (m > MAX_DATA_BITS) begin
            m = MAX_DATA_BITS;
        end
        r = 1;
        while (r < CODE_W && (64'd1 << r) < 64'(m + r + 1)) begin
            r++;
        end
        n = m + r;
        if (n > CODE_W) begin
            n = CODE_W;
        end
        result = '0;
        k = 0;
        for (int pos = 1; pos <= n; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
                if (k < DATA_W) begin
                    result.code_word[pos-1] = word[k];
                end
                k++;
            end
        end
        // Check positions are still zero here, so each group sees only data bits.
        for (int i = 0; i < r && i < 6; i++) begin
            chk = 1 << i;
            par = odd_cfg;
            for (int pos = 1; pos <= n; pos++) begin
                if (pos != chk && (pos & chk) != 0) begin
                    par = par ^ result.code_word[pos-1];
                end
            end
            if (chk <= n) begin
                result.code_word[chk-1] = par;
            end
        end
        result.code_length = LEN_W'(n);
        result.check_count = CHECK_W'(r);
        return result;
    endfunction

    task automatic write_register(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_DATA_BITS) begin
            cfg_data_bits = value[LEN_W-1:0];
        end else begin
            cfg_odd_parity = value[0];
        end
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_codewords.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(input logic [LEN_W-1:0] width_cfg, input logic odd_cfg);
        wait_idle();
        write_register(REG_DATA_BITS, APB_DATA_W'(width_cfg));
        write_register(REG_ODD_PARITY, APB_DATA_W'(odd_cfg));
        settings_used++;
    endtask

    // Leaves s_tvalid high after the transfer so back-to-back words need no gap.
    task automatic send_data_word(input logic [DATA_W-1:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-DATA_W){1'b0}}, word};
        do @(posedge aclk); while (!s_tready);
        pending_codewords.push_back(hamming_encode(word, cfg_data_bits, cfg_odd_parity));
        words_sent++;
    endtask

    function automatic logic [DATA_W-1:0] random_data_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            3: return ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
            default: return raw[DATA_W-1:0];
        endcase
    endfunction

    // Result side: random stall before each transfer, or none in burst phases.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_codewords.size() == 0) begin
                $error("Codeword transfer with nothing expected: m_tdata=%h", m_tdata);
                error_count++;
            end else begin
                oldest_codeword = pending_codewords.pop_front();
                codewords_checked++;
                if (m_tdata[62:0] !== oldest_codeword.code_word) begin
                    $error("code_word: expected %h, actual %h",
                           oldest_codeword.code_word, m_tdata[62:0]);
                    error_count++;
                end
                if (m_tdata[68:63] !== oldest_codeword.code_length) begin
                    $error("code_length: expected %0d, actual %0d",
                           oldest_codeword.code_length, m_tdata[68:63]);
                    error_count++;
                end
                if (m_tdata[71:69] !== oldest_codeword.check_count) begin
                    $error("check_count: expected %0d, actual %0d",
                           oldest_codeword.check_count, m_tdata[71:69]);
                    error_count++;
                end
            end
        end
    end

    task automatic test_reset_defaults();
        send_data_word('0);
        send_data_word(DATA_W'(4'hF));
        send_data_word('1);
        send_data_word(DATA_W'(4'h5));
    endtask

    task automatic test_width_extremes();
        set_config(6'd0, 1'b0);
        send_data_word(DATA_W'(1));
        send_data_word('0);
        set_config(6'd1, 1'b0);
        send_data_word('1);
        set_config(6'd57, 1'b0);
        send_data_word('0);
        send_data_word('1);
        send_data_word(DATA_W'({29{2'b01}}));
        send_data_word(DATA_W'(1) << (DATA_W - 1));
        set_config(6'd63, 1'b0);
        send_data_word('1);
        send_data_word(DATA_W'(1) << (DATA_W - 1));
        set_config(6'd58, 1'b0);
        send_data_word('1);
        set_config(6'd26, 1'b0);
        send_data_word('1);
    endtask

    task automatic test_parity_modes();
        set_config(6'd57, 1'b1);
        send_data_word('0);
        send_data_word('1);
        set_config(6'd1, 1'b1);
        send_data_word('0);
        send_data_word('1);
        set_config(6'd4, 1'b1);
        send_data_word('0);
    endtask

    task automatic test_random_traffic();
        logic [LEN_W-1:0] width_cfg;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0: width_cfg = LEN_W'($urandom_range(0, 63));
                1: width_cfg = LEN_W'($urandom_range(1, 11));
                2: width_cfg = LEN_W'(MAX_DATA_BITS);
                default: width_cfg = LEN_W'($urandom_range(1, MAX_DATA_BITS));
            endcase
            set_config(width_cfg, 1'($urandom_range(0, 1)));
            // Every fourth phase runs both sides flat out.
            no_idle = (phase % 4 == 3);
            for (int w = 0; w < PHASE_WORDS; w++) begin
                send_data_word(random_data_word());
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        aresetn           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        cfg_data_bits     = DATA_BITS_RESET;
        cfg_odd_parity    = 1'b0;
        no_idle           = 1'b0;
        error_count       = 0;
        words_sent        = 0;
        codewords_checked = 0;
        settings_used     = 1;
        cycle_count       = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_width_extremes();
        test_parity_modes();
        test_random_traffic();
        wait_idle();

        $display("Encoded %0d data words and checked %0d codewords over %0d register settings,",
                 words_sent, codewords_checked, settings_used);
        $display("including widths 0, 1, 57 and above 57 with even and odd parity.");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
